// ===== rtl/jac3_pkg.sv =====
// Shared types and constants of the 3x3 Jacobi solver.
`default_nettype none
package jac3_pkg;

	// Quotient bits produced by the serial divider.
	localparam int QBITS = 32;

	// Saturated relative error and signed value limits.
	localparam logic [30:0] ERR_MAX = 31'h7FFF_FFFF;
	localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;

	// Constant terms of the three update equations, in whole units.
	localparam int K1 = 20;
	localparam int K2 = 38;
	localparam int K3 = 34;

	// Divisor magnitudes of the three update equations and their halves.
	localparam logic [31:0] DIV1 = 32'd8;
	localparam logic [31:0] DIV2 = 32'd6;
	localparam logic [31:0] DIV3 = 32'd7;
	localparam logic [35:0] HALF1 = 36'd4;
	localparam logic [35:0] HALF2 = 36'd3;
	localparam logic [35:0] HALF3 = 36'd3;

	// Result word of the divider.
	typedef struct packed {
		logic done;
		logic ovf;
		logic [QBITS-1:0] quo;
	} div_res_t;

endpackage
`default_nettype wire

// ===== rtl/jacobi_3x3_fixed_solver.sv =====
// Top level of the 3x3 Jacobi solver with one shared bit-serial divider.
// Each sweep runs up to six divisions on the serial divider, three for the new values and
// three for the relative errors. A division goes from START through WAIT: the divider takes
// its operands, forms the 32 quotient bits and raises done, or raises done with the overflow
// flag and no bit steps. A zero new value skips its error division. Each sweep ends in EMIT,
// where it waits out a stalled output; an item runs up to MAX_SWEEPS sweeps. A new word is taken
// once the final result is registered. Reset clears control state, threshold 5.0 percent.
`default_nettype none
module jacobi_3x3_fixed_solver #(
	parameter int MAX_SWEEPS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [30:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] x1_start,
	input  wire logic [31:0] x2_start,
	input  wire logic [31:0] x3_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       sweep_number,
	output logic [31:0]      x1_value,
	output logic [31:0]      x2_value,
	output logic [31:0]      x3_value,
	output logic [30:0]      err1_pct,
	output logic [30:0]      err2_pct,
	output logic [30:0]      err3_pct,
	output logic [30:0]      max_err_pct,
	output logic             last,
	output logic             converged
);
	import jac3_pkg::*;

	// The error dividend is |diff| * 100 shifted up by the fraction bits.
	localparam int DW = 40 + FRAC_BITS;
	localparam logic signed [35:0] C1 = 36'(K1 * (1 << FRAC_BITS));
	localparam logic signed [35:0] C2 = 36'(K2 * (1 << FRAC_BITS));
	localparam logic signed [35:0] C3 = 36'(K3 * (1 << FRAC_BITS));

	typedef enum logic [1:0] {IDLE, START, WAIT, EMIT} state_t;

	state_t      state_q;
	logic        err_phase_q;   // Low while new values are divided, high for errors.
	logic [1:0]  idx_q;         // Which unknown is being worked on.
	logic [6:0]  sweep_q;
	logic        neg_q;
	logic [31:0] x_q [3];       // Values from the previous sweep.
	logic [31:0] n_q [3];       // New values of this sweep.
	logic [30:0] e_q [3];
	logic [30:0] thr_q;
	logic        out_valid_q;

	logic                div_start;
	logic [DW-1:0]       div_dividend;
	logic [31:0]         div_divisor;
	div_res_t            div_res;

	// Operand selection for the value divisions.
	logic signed [35:0] ex1, ex2, ex3, num;
	logic [35:0]        num_mag;
	logic [35:0]        half;
	logic [31:0]        vdiv;
	logic               vneg;

	// Operand selection for the error divisions.
	logic [31:0]        nv, ov;
	logic signed [32:0] diff;
	logic [32:0]        ad;
	logic [31:0]        an;
	logic [39:0]        ad100;
	logic               an_zero;

	// Result shaping and sweep bookkeeping.
	logic [31:0] val_res;
	logic [30:0] err_res;
	logic [30:0] em12, em;
	logic        conv, fin;
	logic        out_free;

	assign ex1 = 36'(signed'(x_q[0]));
	assign ex2 = 36'(signed'(x_q[1]));
	assign ex3 = 36'(signed'(x_q[2]));

	always_comb begin
		case (idx_q)
			2'd0: begin
				num  = -C1 - ex2 + (ex3 <<< 1);
				half = HALF1;
				vdiv = DIV1;
			end
			2'd1: begin
				num  = -C2 - (ex1 <<< 1) + ex3;
				half = HALF2;
				vdiv = DIV2;
			end
			default: begin
				num  = -C3 + ex1 + (ex1 <<< 1) + ex2;
				half = HALF3;
				vdiv = DIV3;
			end
		endcase
	end

	// The first two equations divide by a negative constant.
	assign vneg    = num[35] ^ (idx_q != 2'd2);
	assign num_mag = (num[35] ? 36'(-num) : 36'(num)) + half;

	assign nv      = n_q[idx_q];
	assign ov      = x_q[idx_q];
	assign diff    = 33'(signed'(nv)) - 33'(signed'(ov));
	assign ad      = diff[32] ? 33'(-diff) : 33'(diff);
	// The magnitude of the most negative value is 2^31, which still fits.
	assign an      = nv[31] ? 32'(-nv) : nv;
	assign an_zero = (nv == 32'd0);
	assign ad100   = (40'(ad) << 6) + (40'(ad) << 5) + (40'(ad) << 2);

	assign div_start    = (state_q == START) && !(err_phase_q && an_zero);
	assign div_dividend = err_phase_q ? {ad100, FRAC_BITS'(0)} : DW'(num_mag);
	assign div_divisor  = err_phase_q ? an : vdiv;

	jac3_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.res      (div_res)
	);

	// Rounded value with signed saturation; the sign was kept at start.
	always_comb begin
		if (div_res.ovf) begin
			val_res = neg_q ? VAL_MIN : VAL_MAX;
		end else if (neg_q) begin
			val_res = (div_res.quo > VAL_MIN) ? VAL_MIN : 32'(-div_res.quo);
		end else begin
			val_res = div_res.quo[31] ? VAL_MAX : div_res.quo;
		end
	end

	assign err_res = (div_res.ovf || div_res.quo[31]) ? ERR_MAX : div_res.quo[30:0];

	assign em12 = (e_q[0] >= e_q[1]) ? e_q[0] : e_q[1];
	assign em   = (e_q[2] > em12) ? e_q[2] : em12;
	assign conv = (em <= thr_q);
	assign fin  = conv || (sweep_q == 7'(MAX_SWEEPS));

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			err_phase_q <= 1'b0;
			idx_q       <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
			thr_q       <= 31'd327680;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			// In EMIT the output register is refilled below instead.
			if (out_valid_q && !out_stall && state_q != EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						sweep_q     <= 7'd1;
						err_phase_q <= 1'b0;
						idx_q       <= '0;
						state_q     <= START;
					end
				end
				START: begin
					if (err_phase_q && an_zero) begin
						// A zero new value gives a saturated error with no division.
						if (idx_q == 2'd2) begin
							state_q <= EMIT;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end else begin
						state_q <= WAIT;
					end
				end
				WAIT: begin
					if (div_res.done) begin
						if (idx_q == 2'd2) begin
							idx_q <= '0;
							if (err_phase_q) begin
								state_q <= EMIT;
							end else begin
								err_phase_q <= 1'b1;
								state_q     <= START;
							end
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= START;
						end
					end
				end
				EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						idx_q       <= '0;
						err_phase_q <= 1'b0;
						if (fin) begin
							state_q <= IDLE;
						end else begin
							sweep_q <= sweep_q + 7'd1;
							state_q <= START;
						end
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// Datapath registers; these carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == IDLE && in_valid) begin
			x_q[0] <= x1_start;
			x_q[1] <= x2_start;
			x_q[2] <= x3_start;
		end
		if (div_start && !err_phase_q) begin
			neg_q <= vneg;
		end
		if (state_q == START && err_phase_q && an_zero) begin
			e_q[idx_q] <= ERR_MAX;
		end
		if (state_q == WAIT && div_res.done) begin
			if (err_phase_q) begin
				e_q[idx_q] <= err_res;
			end else begin
				n_q[idx_q] <= val_res;
			end
		end
		if (state_q == EMIT && out_free) begin
			sweep_number <= sweep_q;
			x1_value     <= n_q[0];
			x2_value     <= n_q[1];
			x3_value     <= n_q[2];
			err1_pct     <= e_q[0];
			err2_pct     <= e_q[1];
			err3_pct     <= e_q[2];
			max_err_pct  <= em;
			last         <= fin;
			converged    <= conv;
			x_q[0]       <= n_q[0];
			x_q[1]       <= n_q[1];
			x_q[2]       <= n_q[2];
		end
	end

	assign in_stall  = (state_q != IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/jac3_div.sv =====
// Bit-serial restoring divider with a 32-bit quotient and overflow flag.
`default_nettype none
module jac3_div #(
	parameter int DW = 56
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DW-1:0]         dividend,
	input  wire logic [31:0]           divisor,
	output jac3_pkg::div_res_t         res
);
	import jac3_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        ovf_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [31:0] shf_q;
	logic [32:0] trial;
	logic        ge;

	assign trial = {rem_q, shf_q[31]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// A quotient of 2^32 or more is only flagged.
				if (33'(dividend[DW-1:32]) >= {1'b0, divisor}) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q  <= 1'b0;
					busy_q <= 1'b1;
					cnt_q  <= 6'd32;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The partial remainder stays below the divisor, so it fits in 32 bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 32'(dividend[DW-1:32]);
			shf_q <= dividend[31:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			shf_q <= {shf_q[30:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.quo  = shf_q;

endmodule
`default_nettype wire
